FILE: rtl/hpvp_pkg.sv
// Package: shared constants, codes, handshake structs and helpers of the pendant-vertex pruner.
package hpvp_pkg;

  // Cube dimension and the part of it covered by the 256-entry tables
  localparam int unsigned DIM      = 8;
  localparam int unsigned VTX_W    = 8;
  localparam int unsigned TBL_SIZE = 1 << VTX_W;
  localparam int unsigned USE_DIMS = (DIM > VTX_W) ? VTX_W : DIM;
  localparam int unsigned DCNT_W   = (USE_DIMS > 1) ? $clog2(USE_DIMS) : 1;
  localparam int unsigned TOT_W    = $clog2(USE_DIMS + 1) < 2 ? 2 : $clog2(USE_DIMS + 1);

  // Table entry: {visited, remaining degree}
  localparam int unsigned DEG_W    = 4;
  localparam int unsigned ENT_W    = DEG_W + 1;
  localparam logic [DEG_W-1:0] DEG_RESET = DEG_W'(DIM % 16);

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned OUT_W    = 2;
  localparam int unsigned FDIM_W   = 3;
  localparam int unsigned CUT_W    = 32;

  localparam int unsigned PRUNE_TOTAL    = 3;
  localparam int unsigned PENDANT_DEGREE = 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPLY = 2'd0,
    CMD_UNDO  = 2'd1,
    CMD_MARK  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef enum logic [OUT_W-1:0] {
    OUT_CONTINUE = 2'd0,
    OUT_FORCE    = 2'd1,
    OUT_PRUNE    = 2'd2
  } outcome_e;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture request, clear accumulators
    logic issue;   // read next neighbor entry
    logic finish;  // resolve outcome into output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_issue;  // current read is the last of this request
    logic out_free;    // output register can take a result this cycle
  } dp_status_t;

  // True when exactly one bit is set (neighbor of vertex 0)
  function automatic logic single_bit(input logic [VTX_W-1:0] v);
    return (v != '0) && ((v & (v - VTX_W'(1))) == '0);
  endfunction

endpackage

FILE: rtl/hpvp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hpvp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/hpvp_ctrl.sv
// Controller: sequences capture, neighbor reads, drain and result hand-off.
module hpvp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hpvp_pkg::dp_status_t status_i,
  output hpvp_pkg::dp_cmd_t    cmd_o
);
  import hpvp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ISSUE  = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd_o.issue = 1'b1;
        if (status_i.last_issue) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last write-back happens here
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/hpvp_dpath.sv
// Datapath: degree/visited table, neighbor read-modify-write, outcome and cut counter.
module hpvp_dpath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  hpvp_pkg::dp_cmd_t                 cmd_i,
  output hpvp_pkg::dp_status_t              status_o,
  input  logic [hpvp_pkg::CMD_W-1:0]        command_i,
  input  logic [hpvp_pkg::VTX_W-1:0]        vertex_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [hpvp_pkg::OUT_W-1:0]        outcome_o,
  output logic [hpvp_pkg::FDIM_W-1:0]       forced_dimension_o,
  output logic [hpvp_pkg::CUT_W-1:0]        cut_count_o
);
  import hpvp_pkg::*;

  // Captured request
  cmd_e              cmd_q;
  logic [VTX_W-1:0]  vtx_q;
  logic [DCNT_W-1:0] cnt_q;

  // Read address generation
  logic              vis_cmd;
  logic [VTX_W-1:0]  raddr;

  // Write-back stage
  logic              wr_act_q;
  logic [VTX_W-1:0]  wr_addr_q;
  logic [DCNT_W-1:0] wr_dim_q;
  logic              rvalid_q;
  logic [TBL_SIZE-1:0] valid_q;
  logic [ENT_W-1:0]  rdata;
  logic [ENT_W-1:0]  ent;
  logic              ent_vis;
  logic [DEG_W-1:0]  ent_deg;
  logic [DEG_W-1:0]  dec_deg;
  logic              we;
  logic [ENT_W-1:0]  wdata;
  logic              pendant;

  // Accumulators
  logic [TOT_W-1:0]  total_q;
  logic              have_q;
  logic              conflict_q;
  logic [DCNT_W-1:0] fdim_q;

  // Result side
  logic              prune;
  logic              force_nb;
  logic [CUT_W-1:0]  cut_q;
  logic [CUT_W-1:0]  cut_next;
  logic              out_valid_q;
  outcome_e          outcome_q;
  logic [FDIM_W-1:0] fdim_out_q;
  logic [CUT_W-1:0]  cut_out_q;

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= cmd_e'(command_i);
      vtx_q <= vertex_i;
    end
  end

  // Neighbor index counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
    end else if (cmd_i.issue) begin
      cnt_q <= cnt_q + DCNT_W'(1);
    end
  end

  assign vis_cmd = (cmd_q == CMD_MARK) || (cmd_q == CMD_CLEAR);
  assign raddr   = vis_cmd ? vtx_q : (vtx_q ^ (VTX_W'(1) << cnt_q));

  assign status_o.last_issue = vis_cmd || (cnt_q == DCNT_W'(USE_DIMS - 1));
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  // Write-back stage acts in the cycle after the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_act_q <= 1'b0;
      rvalid_q <= 1'b0;
    end else begin
      wr_act_q <= cmd_i.issue;
      rvalid_q <= valid_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      wr_addr_q <= raddr;
      wr_dim_q  <= cnt_q;
    end
  end

  // Entry is at its reset value until first written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we) begin
      valid_q[wr_addr_q] <= 1'b1;
    end
  end

  hpvp_ram #(
    .WIDTH(ENT_W),
    .DEPTH(TBL_SIZE)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(wr_addr_q),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign ent     = rvalid_q ? rdata : {1'b0, DEG_RESET};
  assign ent_vis = ent[DEG_W];
  assign ent_deg = ent[DEG_W-1:0];
  assign dec_deg = ent_deg - DEG_W'(1);

  // Entry update per command
  always_comb begin
    we    = 1'b0;
    wdata = ent;
    case (cmd_q)
      CMD_APPLY: begin
        we    = wr_act_q && !ent_vis;
        wdata = {1'b0, dec_deg};
      end
      CMD_UNDO: begin
        we    = wr_act_q && !ent_vis;
        wdata = {1'b0, ent_deg + DEG_W'(1)};
      end
      CMD_MARK: begin
        we    = wr_act_q;
        wdata = {1'b1, ent_deg};
      end
      CMD_CLEAR: begin
        we    = wr_act_q;
        wdata = {1'b0, ent_deg};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign pendant = (cmd_q == CMD_APPLY) && wr_act_q && !ent_vis
                   && (dec_deg == DEG_W'(PENDANT_DEGREE));

  // Degree-1 neighbor bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= '0;
      have_q     <= 1'b0;
      conflict_q <= 1'b0;
      fdim_q     <= '0;
    end else if (cmd_i.load) begin
      total_q    <= '0;
      have_q     <= 1'b0;
      conflict_q <= 1'b0;
      fdim_q     <= '0;
    end else if (pendant) begin
      if (single_bit(wr_addr_q)) begin
        total_q <= total_q + TOT_W'(1);
      end else if (!have_q && !conflict_q) begin
        have_q  <= 1'b1;
        fdim_q  <= wr_dim_q;
        total_q <= total_q + TOT_W'(1);
      end else begin
        conflict_q <= 1'b1;
      end
    end
  end

  // Outcome resolution
  assign prune    = (cmd_q == CMD_APPLY)
                    && (conflict_q || (total_q >= TOT_W'(PRUNE_TOTAL)));
  assign force_nb = (cmd_q == CMD_APPLY) && have_q;
  assign cut_next = (prune && (cut_q != '1)) ? cut_q + CUT_W'(1) : cut_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cut_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        cut_q       <= cut_next;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      cut_out_q <= cut_next;
      if (prune) begin
        outcome_q  <= OUT_PRUNE;
        fdim_out_q <= '0;
      end else if (force_nb) begin
        outcome_q  <= OUT_FORCE;
        fdim_out_q <= FDIM_W'(fdim_q);
      end else begin
        outcome_q  <= OUT_CONTINUE;
        fdim_out_q <= '0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign outcome_o          = outcome_q;
  assign forced_dimension_o = fdim_out_q;
  assign cut_count_o        = cut_out_q;

endmodule

FILE: rtl/hypercube_pendant_vertex_pruner.sv
// Top level: pendant-vertex pruning unit for a hypercube Hamiltonian path search.
//
// Input channel (in_valid_i / in_stall_o) takes one request: command_i and
// vertex_i. Apply and undo walk the DIM neighbors of the vertex (up to 8),
// updating their remaining degree; mark and clear set or clear the visited
// bit of the vertex itself. Every request gives exactly one result on the
// output channel (out_valid_o / out_stall_i): outcome_o, forced_dimension_o
// and cut_count_o (prune count after this request, saturating).
// Sequence: an accepted request is captured, then its table reads are issued
// (8 neighbor reads for apply/undo at DIM = 8, 1 read for mark/clear), the
// last write-back drains and the outcome is registered. The next request can
// be taken in the cycle the result appears. The degree table does one neighbor
// read and one write-back per cycle while the reads are issued.
// Reset clears all visited bits, sets every degree to DIM (tracked by a
// written flag per entry, so no clearing pass) and zeroes the cut counter.
// A stalled result holds in the output register; the block finishes the
// next request and waits with it until the output register frees up.
module hypercube_pendant_vertex_pruner (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [hpvp_pkg::CMD_W-1:0]   command_i,
  input  logic [hpvp_pkg::VTX_W-1:0]   vertex_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [hpvp_pkg::OUT_W-1:0]   outcome_o,
  output logic [hpvp_pkg::FDIM_W-1:0]  forced_dimension_o,
  output logic [hpvp_pkg::CUT_W-1:0]   cut_count_o
);
  import hpvp_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  hpvp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (dp_status),
    .cmd_o     (dp_cmd)
  );

  hpvp_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (dp_cmd),
    .status_o          (dp_status),
    .command_i         (command_i),
    .vertex_i          (vertex_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .outcome_o         (outcome_o),
    .forced_dimension_o(forced_dimension_o),
    .cut_count_o       (cut_count_o)
  );

endmodule

FILE: rtl/hpvp_checker.sv
// Checker: port-level assertions for the pruner, bound to the top level.
module hpvp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [hpvp_pkg::OUT_W-1:0]   outcome_o,
  input logic [hpvp_pkg::FDIM_W-1:0]  forced_dimension_o,
  input logic [hpvp_pkg::CUT_W-1:0]   cut_count_o
);
  import hpvp_pkg::*;

  // One request at a time: busy right after taking one
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while previous one in flight");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(outcome_o)
      && $stable(cut_count_o) && $stable(forced_dimension_o))
    else $error("stalled result changed");

  // Dimension only reported with a forced neighbor
  a_fdim_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outcome_o != OUT_FORCE) |-> forced_dimension_o == '0)
    else $error("forced dimension without forced outcome");

  // A prune is always counted
  a_prune_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outcome_o == OUT_PRUNE) |-> cut_count_o != '0)
    else $error("prune reported with zero cut count");

  // Outcome code is one of continue, force, prune
  a_outcome_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (outcome_o == OUT_CONTINUE) || (outcome_o == OUT_FORCE)
      || (outcome_o == OUT_PRUNE))
    else $error("undefined outcome code");

endmodule

bind hypercube_pendant_vertex_pruner hpvp_checker u_hpvp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .outcome_o         (outcome_o),
  .forced_dimension_o(forced_dimension_o),
  .cut_count_o       (cut_count_o)
);

FILE: test/hypercube_pendant_vertex_pruner_tb.sv
// Testbench: pendant-vertex pruner driven by hypercube walks and noise, checked against a predictor.
module hypercube_pendant_vertex_pruner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hpvp_pkg::*;

  localparam int RANDOM_ITEMS = 1900;
  localparam int QUIET_LIMIT  = 2000;
  localparam int SETTLE_CYCLES = 20;

  // One request waiting to be sent; hold means wait until nothing is outstanding
  typedef struct {
    cmd_e            cmd;
    logic [VTX_W-1:0] vtx;
    bit              hold;
  } request_t;

  typedef struct packed {
    outcome_e          outcome;
    logic [FDIM_W-1:0] fdim;
    logic [CUT_W-1:0]  cuts;
  } verdict_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [CMD_W-1:0]    command_i = '0;
  logic [VTX_W-1:0]    vertex_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [OUT_W-1:0]    outcome_o;
  logic [FDIM_W-1:0]   forced_dimension_o;
  logic [CUT_W-1:0]    cut_count_o;

  // Predictor state
  logic [DEG_W-1:0] deg_tab [TBL_SIZE];
  bit               seen_tab [TBL_SIZE];
  logic [CUT_W-1:0] cut_tally;

  // Walk planner's view of the visited marks
  bit walk_seen [TBL_SIZE];

  request_t request_q [$];
  verdict_t verdict_q [$];
  int       plan_size = 1;
  int       acc_in = 0;
  int       acc_out = 0;
  int       quiet = 0;
  int       faults = 0;

  hypercube_pendant_vertex_pruner dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .vertex_i           (vertex_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .outcome_o          (outcome_o),
    .forced_dimension_o (forced_dimension_o),
    .cut_count_o        (cut_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Degree bookkeeping and forced/prune decision for one request
  function automatic verdict_t judge_request(cmd_e cmd, logic [VTX_W-1:0] v);
    verdict_t          r;
    logic [VTX_W-1:0]  nb;
    int unsigned       hits;
    bit                forced;
    bit                clash;
    logic [FDIM_W-1:0] fdim_at;
    r = '{OUT_CONTINUE, '0, '0};
    hits = 0;
    forced = 1'b0;
    clash = 1'b0;
    fdim_at = '0;
    case (cmd)
      CMD_APPLY: begin
        for (int d = 0; d < USE_DIMS; d++) begin
          nb = v ^ (VTX_W'(1) << d);
          if (!seen_tab[nb]) begin
            deg_tab[nb] = deg_tab[nb] - 1'b1;
            if (deg_tab[nb] == PENDANT_DEGREE) begin
              // neighbors of vertex 0 still have a way out, others must be taken next
              if ($countones(nb) == 1) begin
                hits++;
              end else if (!forced && !clash) begin
                forced = 1'b1;
                fdim_at = FDIM_W'(d);
                hits++;
              end else begin
                clash = 1'b1;
              end
            end
          end
        end
        if (clash || hits >= PRUNE_TOTAL) begin
          r.outcome = OUT_PRUNE;
          if (cut_tally != '1) cut_tally++;
        end else if (forced) begin
          r.outcome = OUT_FORCE;
          r.fdim = fdim_at;
        end
      end
      CMD_UNDO: begin
        for (int d = 0; d < USE_DIMS; d++) begin
          nb = v ^ (VTX_W'(1) << d);
          if (!seen_tab[nb]) deg_tab[nb] = deg_tab[nb] + 1'b1;
        end
      end
      CMD_MARK:  seen_tab[v] = 1'b1;
      default:   seen_tab[v] = 1'b0;
    endcase
    r.cuts = cut_tally;
    return r;
  endfunction

  function automatic void push_req(cmd_e cmd, logic [VTX_W-1:0] v, bit hold);
    request_t r;
    r.cmd = cmd;
    r.vtx = v;
    r.hold = hold;
    request_q.insert(request_q.size(), r);
    if (cmd == CMD_MARK) walk_seen[v] = 1'b1;
    if (cmd == CMD_CLEAR) walk_seen[v] = 1'b0;
  endfunction

  // Search-like walk: mark+apply forward, undo+clear on backtrack
  task automatic plan_walk();
    logic [VTX_W-1:0] trail [$];
    logic [VTX_W-1:0] here;
    logic [VTX_W-1:0] nb;
    logic [VTX_W-1:0] pick;
    int               cap;
    int               steps;
    int               found;
    int               free_cnt;
    int               best;
    int               back;
    bit               greedy;
    here = VTX_W'($urandom_range(TBL_SIZE - 1));
    if (walk_seen[here]) return;
    cap = ($urandom_range(3) == 0) ? $urandom_range(100, 170) : $urandom_range(6, 50);
    greedy = ($urandom_range(9) < 7);
    push_req(CMD_MARK, here, $urandom_range(3) == 0);
    push_req(CMD_APPLY, here, 1'b0);
    trail.insert(trail.size(), here);
    steps = 0;
    while (trail.size() < cap && steps < 2 * cap) begin
      steps++;
      here = trail[$];
      found = 0;
      best = 99;
      pick = here;
      // greedy walks head for the neighbor with fewest free neighbors
      for (int d = 0; d < USE_DIMS; d++) begin
        nb = here ^ (VTX_W'(1) << d);
        if (!walk_seen[nb]) begin
          free_cnt = 0;
          for (int e = 0; e < USE_DIMS; e++) free_cnt += !walk_seen[nb ^ (VTX_W'(1) << e)];
          found++;
          if (greedy ? (free_cnt < best || (free_cnt == best && $urandom_range(1) == 0))
                     : ($urandom_range(found - 1) == 0)) begin
            best = free_cnt;
            pick = nb;
          end
        end
      end
      if (found == 0) break;
      push_req(CMD_MARK, pick, 1'b0);
      push_req(CMD_APPLY, pick, 1'b0);
      trail.insert(trail.size(), pick);
      if ($urandom_range(7) == 0) begin
        back = $urandom_range(1, 3);
        while (back > 0 && trail.size() > 1) begin
          here = trail.pop_back();
          push_req(CMD_UNDO, here, 1'b0);
          push_req(CMD_CLEAR, here, 1'b0);
          back--;
        end
      end
    end
    // full unwind, except now and then the walk is abandoned as is
    if ($urandom_range(9) != 0) begin
      while (trail.size() != 0) begin
        here = trail.pop_back();
        push_req(CMD_UNDO, here, 1'b0);
        push_req(CMD_CLEAR, here, 1'b0);
      end
    end
  endtask

  // Request driver
  always @(posedge clk_i) begin : driver
    request_t req;
    int       gap_pct;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      case ((acc_in * 3) / plan_size)
        0:       gap_pct = 18;
        1:       gap_pct = 76;
        default: gap_pct = 0;
      endcase
      if (in_valid_i && !in_stall_o) begin
        verdict_q.insert(verdict_q.size(), judge_request(cmd_e'(command_i), vertex_i));
        acc_in <= acc_in + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (request_q.size() != 0 && $urandom_range(99) >= gap_pct &&
            (!request_q[0].hold || (!in_valid_i && acc_in == acc_out))) begin
          req = request_q.pop_front();
          in_valid_i <= 1'b1;
          command_i  <= req.cmd;
          vertex_i   <= req.vtx;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor and checker
  always @(posedge clk_i) begin : monitor
    verdict_t want;
    int       stall_pct;
    if (rst_ni) begin
      case ((acc_in * 3) / plan_size)
        0:       stall_pct = 76;
        1:       stall_pct = 18;
        default: stall_pct = 0;
      endcase
      if (out_valid_o && !out_stall_i) begin
        acc_out <= acc_out + 1;
        if (verdict_q.size() == 0) begin
          if (faults < 10) $display("[%0t] result %0d arrived with no request outstanding",
                                    $time, acc_out);
          faults++;
        end else begin
          want = verdict_q.pop_front();
          if (outcome_o !== want.outcome || forced_dimension_o !== want.fdim ||
              cut_count_o !== want.cuts) begin
            if (faults < 10) begin
              $display("[%0t] result %0d mismatch: expected outcome %0d dim %0d cuts %0d",
                       $time, acc_out, want.outcome, want.fdim, want.cuts);
              $display("            got outcome %0d dim %0d cuts %0d",
                       outcome_o, forced_dimension_o, cut_count_o);
            end
            faults++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : watchdog
    while (quiet < QUIET_LIMIT) @(posedge clk_i);
    $display("** hypercube_pendant_vertex_pruner: FAILED **");
    $finish;
  end

  initial begin : main
    int base;
    foreach (deg_tab[i]) begin
      deg_tab[i] = DEG_RESET;
      seen_tab[i] = 1'b0;
      walk_seen[i] = 1'b0;
    end
    cut_tally = '0;

    // Extremes of the vertex field and every command
    push_req(CMD_APPLY, 8'hFF, 1'b0);
    push_req(CMD_UNDO, 8'hFF, 1'b0);
    push_req(CMD_MARK, 8'h00, 1'b0);
    push_req(CMD_CLEAR, 8'h00, 1'b0);
    // All neighbors of 5A down to degree 2
    repeat (6) push_req(CMD_APPLY, 8'h5A, 1'b0);
    // 58 hidden, so 59 forces only 5B (dimension 1)
    push_req(CMD_MARK, 8'h58, 1'b1);
    push_req(CMD_APPLY, 8'h59, 1'b0);
    push_req(CMD_CLEAR, 8'h58, 1'b0);
    // Many forced neighbors at once, then degrees wrap below zero
    repeat (3) push_req(CMD_APPLY, 8'h5A, 1'b0);
    // Undo wraps 15 back to 0
    push_req(CMD_UNDO, 8'h5A, 1'b0);
    push_req(CMD_UNDO, 8'h59, 1'b0);
    // Neighbors of vertex 0 reach degree 1 together: prune by count
    repeat (7) push_req(CMD_APPLY, 8'h00, 1'b0);

    // Mostly walks, some random noise bursts
    base = request_q.size();
    while (request_q.size() < base + RANDOM_ITEMS) begin
      if ($urandom_range(99) < 12) begin
        repeat ($urandom_range(1, 6)) begin
          push_req(cmd_e'($urandom_range(3)), VTX_W'($urandom_range(TBL_SIZE - 1)), 1'b0);
        end
      end else begin
        plan_walk();
      end
    end
    plan_size = request_q.size();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sample at the falling edge so the driver's updates have settled
    while (request_q.size() != 0 || in_valid_i) @(negedge clk_i);
    while (verdict_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (faults == 0 && verdict_q.size() == 0) begin
      $display("** hypercube_pendant_vertex_pruner: PASSED **");
    end else begin
      $display("** hypercube_pendant_vertex_pruner: FAILED **");
    end
    $finish;
  end

endmodule
